// ----- hdl/lpps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpps_pkg;

  // Width of one reflectance sample.
  localparam int SAMPLE_BITS = 12;

  // Widths of the configuration registers and of the arithmetic.
  localparam int THR_W   = 12;
  localparam int GAIN_W  = 7;
  localparam int SCALE_W = 4;
  localparam int DUTY_W  = 8;
  localparam int RAW_W   = 4;
  localparam int SERR_W  = 8;
  localparam int DIFF_W  = 9;
  localparam int PD_W    = 17;
  localparam int CORR_W  = 16;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEFT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RIGHT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE     = 3'd6;

  // Register values after reset.
  localparam logic [THR_W-1:0]   RST_LINE_THRESHOLD = 12'd1500;
  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP      = 7'd10;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV     = 7'd10;
  localparam logic [SCALE_W-1:0] RST_ERROR_SCALE    = 4'd1;
  localparam logic [DUTY_W-1:0]  RST_MAX_LEFT       = 8'd50;
  localparam logic [DUTY_W-1:0]  RST_MAX_RIGHT      = 8'd50;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
    logic [SAMPLE_BITS-1:0] sample_d;
    logic [SAMPLE_BITS-1:0] sample_e;
    logic [SAMPLE_BITS-1:0] sample_f;
  } frame_t;

  typedef struct packed {
    logic [DUTY_W-1:0]        left_duty;
    logic [DUTY_W-1:0]        right_duty;
    logic                     drive_on;
    logic signed [SERR_W-1:0] scaled_error;
    logic signed [CORR_W-1:0] correction;
  } drive_t;

  typedef struct packed {
    logic                    hit;
    logic signed [RAW_W-1:0] err;
  } pos_t;

  // Sensor pattern (bit 5 is the leftmost sensor) to raw position error.
  function automatic pos_t pattern_pos(input logic [5:0] pat);
    pos_t r;
    r.hit = 1'b1;
    case (pat)
      6'b000001: r.err = -4'sd7;
      6'b000011: r.err = -4'sd6;
      6'b000010: r.err = -4'sd4;
      6'b000110: r.err = -4'sd3;
      6'b000100: r.err = -4'sd1;
      6'b001100: r.err = 4'sd0;
      6'b001000: r.err = 4'sd1;
      6'b011000: r.err = 4'sd3;
      6'b010000: r.err = 4'sd4;
      6'b111000: r.err = 4'sd6;
      6'b100000: r.err = 4'sd7;
      default: begin
        r.hit = 1'b0;
        r.err = 4'sd0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lpps_bitcmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Six-lane bit-serial comparator. Each lane checks sample <= threshold,
// one bit per cycle, least significant bit first.
module lpps_bitcmp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire lpps_pkg::frame_t                frame,
  input  wire logic [lpps_pkg::SAMPLE_BITS-1:0] thr,
  output logic                                 done,
  output logic [5:0]                           pattern
);
  import lpps_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic [SAMPLE_BITS-1:0] lane [6];
  logic [SAMPLE_BITS-1:0] thr_sh;
  logic [5:0]             le;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SAMPLE_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Lane 5 carries the leftmost sensor so that le lines up with the pattern.
  always_ff @(posedge clk) begin
    if (start) begin
      lane[5] <= frame.sample_a;
      lane[4] <= frame.sample_b;
      lane[3] <= frame.sample_c;
      lane[2] <= frame.sample_d;
      lane[1] <= frame.sample_e;
      lane[0] <= frame.sample_f;
      thr_sh  <= thr;
      le      <= 6'b111111;
    end else if (busy) begin
      for (int i = 0; i < 6; i++) begin
        le[i]   <= (~lane[i][0] & thr_sh[0]) | (~(lane[i][0] ^ thr_sh[0]) & le[i]);
        lane[i] <= lane[i] >> 1;
      end
      thr_sh <= thr_sh >> 1;
    end
  end

  assign pattern = le;

endmodule

`default_nettype wire

// ----- hdl/lpps_pdmac.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Serial PD multiply-accumulate: kp*scaled + kd*diff, one gain bit per cycle.
module lpps_pdmac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [lpps_pkg::SERR_W-1:0]  scaled,
  input  wire logic signed [lpps_pkg::DIFF_W-1:0]  diff,
  input  wire logic [lpps_pkg::GAIN_W-1:0]         kp,
  input  wire logic [lpps_pkg::GAIN_W-1:0]         kd,
  output logic                                     done,
  output logic signed [lpps_pkg::PD_W-1:0]         pd
);
  import lpps_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  logic signed [PD_W-1:0] mp;
  logic signed [PD_W-1:0] md;
  logic [GAIN_W-1:0]      gp;
  logic [GAIN_W-1:0]      gd;
  logic signed [PD_W-1:0] acc;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(GAIN_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mp  <= PD_W'(scaled);
      md  <= PD_W'(diff);
      gp  <= kp;
      gd  <= kd;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + (gp[0] ? mp : '0) + (gd[0] ? md : '0);
      mp  <= mp <<< 1;
      md  <= md <<< 1;
      gp  <= gp >> 1;
      gd  <= gd >> 1;
    end
  end

  assign pd = acc;

endmodule

`default_nettype wire

// ----- hdl/line_position_pd_steering_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Line-position PD steering for a differential-drive robot.
//
// The frame channel (frame_valid / frame_ready / frame) takes one item of
// six reflectance samples, leftmost sensor first. The drive channel
// (drive_valid / drive_ready / drive) returns one item per frame with the
// two wheel duties, the drive enable, the scaled position error and the
// PD correction. Registers are written through cfg_we / cfg_index /
// cfg_data, one register per cycle; the user must write them only while
// no item is in flight, as the core itself does not enforce this.
//
// An accepted frame passes the six-lane bit-serial threshold compare, which
// steps through the sample bits, the map step, the PD multiply-accumulate,
// which steps through the gain bits, and the final step, which loads the
// output register; with the loop disabled it goes straight to the final
// step. The core takes one item at a time; frame_ready rises again once the
// result sits in the output register, so a new frame can be taken while the
// drive item still waits. If the receiver stalls with a result already
// waiting, the next result holds in its final step until the register frees up.
// Reset (synchronous, active high) restores the register defaults, stops
// the loop and clears the held raw error and the prior scaled error.
module line_position_pd_steering_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            frame_valid,
  output logic                                 frame_ready,
  input  wire lpps_pkg::frame_t                frame,
  output logic                                 drive_valid,
  input  wire logic                            drive_ready,
  output lpps_pkg::drive_t                     drive,
  input  wire logic                            cfg_we,
  input  wire logic [lpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpps_pkg::CFG_W-1:0]      cfg_data
);
  import lpps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_MAP  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // Configuration registers.
  logic [THR_W-1:0]   line_threshold;
  logic [GAIN_W-1:0]  gain_prop;
  logic [GAIN_W-1:0]  gain_deriv;
  logic [SCALE_W-1:0] error_scale;
  logic [DUTY_W-1:0]  max_left;
  logic [DUTY_W-1:0]  max_right;
  logic               run_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= RST_LINE_THRESHOLD;
      gain_prop      <= RST_GAIN_PROP;
      gain_deriv     <= RST_GAIN_DERIV;
      error_scale    <= RST_ERROR_SCALE;
      max_left       <= RST_MAX_LEFT;
      max_right      <= RST_MAX_RIGHT;
      run_enable     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_THRESHOLD: line_threshold <= cfg_data[THR_W-1:0];
        REG_GAIN_PROP:      gain_prop      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:     gain_deriv     <= cfg_data[GAIN_W-1:0];
        REG_ERROR_SCALE:    error_scale    <= cfg_data[SCALE_W-1:0];
        REG_MAX_LEFT:       max_left       <= cfg_data[DUTY_W-1:0];
        REG_MAX_RIGHT:      max_right      <= cfg_data[DUTY_W-1:0];
        REG_RUN_ENABLE:     run_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The threshold is compared at sample width: truncated when samples are
  // narrower than the register, zero-extended when they are wider.
  logic [SAMPLE_BITS+THR_W-1:0] thr_wide;
  assign thr_wide = {{SAMPLE_BITS{1'b0}}, line_threshold};

  state_t state;
  state_t state_next;

  logic                    accept;
  logic                    cmp_done;
  logic [5:0]              pattern;
  logic                    mac_start;
  logic                    mac_done;
  logic signed [PD_W-1:0]  pd;
  logic                    fin_load;
  logic                    idle_res;

  assign frame_ready = (state == S_IDLE);
  assign accept      = frame_valid && frame_ready;
  assign mac_start   = (state == S_MAP);
  assign fin_load    = (state == S_FIN) && (!drive_valid || drive_ready);

  lpps_bitcmp u_cmp (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && run_enable),
    .frame   (frame),
    .thr     (thr_wide[SAMPLE_BITS-1:0]),
    .done    (cmp_done),
    .pattern (pattern)
  );

  // Position lookup and scaling. These run in the single map step, after
  // the pattern has settled.
  pos_t                      pos;
  logic signed [RAW_W-1:0]   raw_now;
  logic signed [SERR_W-1:0]  raw_ext;
  logic signed [SERR_W-1:0]  scale_ext;
  logic signed [SERR_W-1:0]  scaled_now;
  logic signed [DIFF_W-1:0]  diff_now;
  logic signed [RAW_W-1:0]   held_raw_error;
  logic signed [SERR_W-1:0]  prior_scaled_error;
  logic signed [SERR_W-1:0]  scaled;

  assign pos        = pattern_pos(pattern);
  assign raw_now    = pos.hit ? pos.err : held_raw_error;
  assign raw_ext    = SERR_W'(raw_now);
  assign scale_ext  = SERR_W'(error_scale);
  assign scaled_now = SERR_W'(raw_ext * scale_ext);
  assign diff_now   = DIFF_W'(scaled_now) - DIFF_W'(prior_scaled_error);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_raw_error     <= '0;
      prior_scaled_error <= '0;
    end else if (state == S_MAP) begin
      held_raw_error     <= raw_now;
      prior_scaled_error <= scaled_now;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAP) begin
      scaled <= scaled_now;
    end
  end

  lpps_pdmac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .scaled (scaled_now),
    .diff   (diff_now),
    .kp     (gain_prop),
    .kd     (gain_deriv),
    .done   (mac_done),
    .pd     (pd)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = run_enable ? S_CMP : S_FIN;
        end
      end
      S_CMP: begin
        if (cmp_done) begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (mac_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idle_res <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        idle_res <= !run_enable;
      end
    end
  end

  // Wheel duties and saturated correction. A positive correction slows the
  // right wheel, a negative one slows the left wheel; each floors at zero.
  logic                   pd_neg;
  logic signed [PD_W-1:0] pd_mag;
  logic [DUTY_W-1:0]      left_now;
  logic [DUTY_W-1:0]      right_now;
  logic signed [CORR_W-1:0] corr_now;

  assign pd_neg = pd[PD_W-1];
  assign pd_mag = pd_neg ? -pd : pd;

  always_comb begin
    if (pd_neg) begin
      right_now = max_right;
      left_now  = (pd_mag > PD_W'(max_left)) ? '0 : max_left - pd_mag[DUTY_W-1:0];
    end else begin
      left_now  = max_left;
      right_now = (pd_mag > PD_W'(max_right)) ? '0 : max_right - pd_mag[DUTY_W-1:0];
    end
    if (pd[PD_W-1] != pd[PD_W-2]) begin
      corr_now = pd_neg ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      corr_now = pd[CORR_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (fin_load) begin
      drive_valid <= 1'b1;
    end else if (drive_ready) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      if (idle_res) begin
        drive <= '0;
      end else begin
        drive.left_duty    <= left_now;
        drive.right_duty   <= right_now;
        drive.drive_on     <= 1'b1;
        drive.scaled_error <= scaled;
        drive.correction   <= corr_now;
      end
    end
  end

endmodule

`default_nettype wire
